### sv/lmfeb_pkg.sv
// Shared constants, step codes and controller/datapath interface types for the line fit block.
package lmfeb_pkg;

    localparam int MAX_PAIRS  = 1024;
    localparam int KEY_BITS   = 24;
    localparam int VALUE_BITS = 24;
    localparam int AW         = $clog2(MAX_PAIRS);
    localparam int CW         = $clog2(MAX_PAIRS + 1);

    // accumulator widths
    localparam int SKW  = KEY_BITS + AW;
    localparam int SVW  = VALUE_BITS + AW;
    localparam int SKKW = 2 * KEY_BITS + AW;
    localparam int SKVW = KEY_BITS + VALUE_BITS + AW;
    localparam int DENW = SKKW + CW;

    // shared multiplier and divider widths
    localparam int MA_W = 70;
    localparam int MB_W = 34;
    localparam int MP_W = MA_W + MB_W;
    localparam int DN_W = 128;
    localparam int DR_W = MP_W + 1;

    localparam logic [31:0] CLAMP_FRAC = 32'd4294966866;

    // fit steps
    localparam logic [3:0] ST_MEAN  = 4'd0;
    localparam logic [3:0] ST_NKK   = 4'd1;
    localparam logic [3:0] ST_KK    = 4'd2;
    localparam logic [3:0] ST_NKV   = 4'd3;
    localparam logic [3:0] ST_KV    = 4'd4;
    localparam logic [3:0] ST_DENR  = 4'd5;
    localparam logic [3:0] ST_SLOPE = 4'd6;
    localparam logic [3:0] ST_NVMIN = 4'd7;
    localparam logic [3:0] ST_NRNG  = 4'd8;
    localparam logic [3:0] ST_ICPT  = 4'd9;

    typedef struct packed {
        logic          load;
        logic          acc;
        logic          mul_go;
        logic          div_go;
        logic [3:0]    step;
        logic          rd_go;
        logic [AW-1:0] rd_addr;
        logic          out_go;
    } dp_cmd_t;

    typedef struct packed {
        logic          last;
        logic          mul_done;
        logic          div_done;
        logic          degen;
        logic          pass_busy;
        logic [CW-1:0] n_pairs;
    } dp_stat_t;

endpackage

### sv/linear_model_fit_error_bound_top.sv
// Top level of the least-squares line fit with maximum position error.
//
// Input channel: key, value and last are taken at a rising edge where start
// is high and busy is low. Each item is first registered, then accumulated
// into the sums and written to the key store; busy covers the second step.
// An item flagged last starts the fit, which runs on one shared shift-add
// multiplier (7 products) and one restoring divider (3 quotients), then a
// pipelined pass that reads one stored key per cycle from the key store.
// When all keys are equal the slope and intercept steps are skipped.
// Result channel: on done high for one cycle, all result ports are valid;
// the receiver cannot stall, so results are never held back. busy drops in
// the same cycle, and the next batch may start at once.
// Reset clears all sums, counters and flags; the key store needs no clearing
// because only keys written in the current batch are read.
module linear_model_fit_error_bound_top import lmfeb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [23:0]        key,
    input  logic [23:0]        value,
    input  logic               last,
    output logic               done,
    output logic signed [63:0] slope_q,
    output logic [31:0]        intercept_q,
    output logic [39:0]        key_mean_q,
    output logic [10:0]        max_offset,
    output logic [10:0]        pair_count,
    output logic               degenerate,
    output logic               overflowed
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lmfeb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    lmfeb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key),
        .value       (value),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat),
        .slope_q     (slope_q),
        .intercept_q (intercept_q),
        .key_mean_q  (key_mean_q),
        .max_offset  (max_offset),
        .pair_count  (pair_count),
        .degenerate  (degenerate),
        .overflowed  (overflowed),
        .done        (done)
    );

endmodule

### sv/lmfeb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmfeb_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/lmfeb_mul.sv
// Shift-add multiplier, one bit of the short operand per cycle.
module lmfeb_mul import lmfeb_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MA_W-1:0] a,
    input  logic [MB_W-1:0] b,
    output logic [MP_W-1:0] p,
    output logic            done
);

    logic [MP_W-1:0] a_reg;
    logic [MB_W-1:0] b_reg;
    logic [MP_W-1:0] p_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(MB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial sum
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= MP_W'(a);
            b_reg <= b;
            p_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                p_reg <= p_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign p    = p_reg;
    assign done = done_reg;

endmodule

### sv/lmfeb_div.sv
// Restoring divider, one quotient bit per cycle.
module lmfeb_div import lmfeb_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DN_W-1:0] num,
    input  logic [MP_W-1:0] den,
    output logic [DN_W-1:0] q,
    output logic            done
);

    logic [DR_W-1:0] r_reg;
    logic [DN_W-1:0] q_reg;
    logic [MP_W-1:0] d_reg;
    logic [6:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DR_W-1:0] rs;
    logic [DR_W-1:0] diff;
    logic            ge;

    // trial subtract
    always_comb
    begin
        rs   = {r_reg[DR_W-2:0], q_reg[DN_W-1]};
        ge   = rs >= {1'b0, d_reg};
        diff = rs - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            q_reg <= num;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff : rs;
            q_reg <= {q_reg[DN_W-2:0], ge};
        end
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule

### sv/lmfeb_dp.sv
// Datapath: item accumulation, key store, fit arithmetic and the error pass pipeline.
module lmfeb_dp import lmfeb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [23:0]        key,
    input  logic [23:0]        value,
    input  logic               last,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic signed [63:0] slope_q,
    output logic [31:0]        intercept_q,
    output logic [39:0]        key_mean_q,
    output logic [10:0]        max_offset,
    output logic [10:0]        pair_count,
    output logic               degenerate,
    output logic               overflowed,
    output logic               done
);

    // item registers
    logic [KEY_BITS-1:0]   k_in_reg;
    logic [VALUE_BITS-1:0] v_in_reg;
    logic                  last_reg;

    // batch accumulators
    logic [CW-1:0]         n_reg;
    logic [SKW-1:0]        ksum_reg;
    logic [SKKW-1:0]       kksum_reg;
    logic [SVW-1:0]        vsum_reg;
    logic [SKVW-1:0]       kvsum_reg;
    logic [VALUE_BITS-1:0] vmin_reg;
    logic [VALUE_BITS-1:0] vmax_reg;
    logic                  ovf_reg;

    // fit results
    logic [39:0]     mean_reg;
    logic [DENW-1:0] a_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW-1:0] mag_reg;
    logic            sraw_reg;
    logic [MP_W-1:0] dv_reg;
    logic [63:0]     slope_reg;
    logic [63:0]     smag_reg;
    logic            sneg_reg;
    logic            degen_reg;
    logic [SVW-1:0]  inum_reg;
    logic [MP_W-1:0] iden_reg;
    logic [31:0]     icpt_reg;
    logic [10:0]     max_reg;

    // output registers
    logic [63:0] o_slope_reg;
    logic [31:0] o_icpt_reg;
    logic [39:0] o_mean_reg;
    logic [10:0] o_max_reg;
    logic [10:0] o_n_reg;
    logic        o_degen_reg;
    logic        o_ovf_reg;
    logic        done_reg;

    logic                  full;
    logic [VALUE_BITS-1:0] rng;
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [MP_W-1:0]       mul_p;
    logic                  mul_done;
    logic [DN_W-1:0]       div_num;
    logic [MP_W-1:0]       div_den;
    logic [DN_W-1:0]       div_q;
    logic                  div_done;
    logic [KEY_BITS-1:0]   rdata;
    logic [DENW-1:0]       p_lo;

    assign full = n_reg == CW'(MAX_PAIRS);
    assign rng  = (vmax_reg > vmin_reg) ? (vmax_reg - vmin_reg) : VALUE_BITS'(1);
    assign p_lo = mul_p[DENW-1:0];

    lmfeb_ram #(.W(KEY_BITS), .D(MAX_PAIRS)) u_store (
        .clk   (clk),
        .we    (cmd.acc && !full),
        .waddr (n_reg[AW-1:0]),
        .wdata (k_in_reg),
        .re    (cmd.rd_go),
        .raddr (cmd.rd_addr),
        .rdata (rdata)
    );

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            ST_NKK:
            begin
                mul_a = MA_W'(kksum_reg);
                mul_b = MB_W'(n_reg);
            end
            ST_KK:
            begin
                mul_a = MA_W'(ksum_reg);
                mul_b = MB_W'(ksum_reg);
            end
            ST_NKV:
            begin
                mul_a = MA_W'(kvsum_reg);
                mul_b = MB_W'(n_reg);
            end
            ST_KV:
            begin
                mul_a = MA_W'(ksum_reg);
                mul_b = MB_W'(vsum_reg);
            end
            ST_DENR:
            begin
                mul_a = MA_W'(den_reg);
                mul_b = MB_W'(rng);
            end
            ST_NVMIN:
            begin
                mul_a = MA_W'(vmin_reg);
                mul_b = MB_W'(n_reg);
            end
            ST_NRNG:
            begin
                mul_a = MA_W'(rng);
                mul_b = MB_W'(n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operand select
    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (cmd.step)
            ST_MEAN:
            begin
                div_num = DN_W'({ksum_reg, 16'd0});
                div_den = MP_W'(n_reg);
            end
            ST_SLOPE:
            begin
                div_num = DN_W'({mag_reg, 47'd0});
                div_den = dv_reg;
            end
            ST_ICPT:
            begin
                div_num = DN_W'({inum_reg, 32'd0});
                div_den = iden_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    lmfeb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    lmfeb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .q     (div_q),
        .done  (div_done)
    );

    // slope saturation
    logic        sat_pos;
    logic        sat_neg;
    logic [63:0] smag_new;
    logic [63:0] slope_new;
    logic        sneg_new;

    always_comb
    begin
        sat_pos = div_q[DN_W-1:63] != '0;
        sat_neg = (div_q[DN_W-1:64] != '0) || (div_q[63] && (div_q[62:0] != '0));
        if (!sraw_reg)
        begin
            smag_new  = sat_pos ? 64'h7FFF_FFFF_FFFF_FFFF : div_q[63:0];
            slope_new = smag_new;
            sneg_new  = 1'b0;
        end
        else
        begin
            smag_new  = sat_neg ? 64'h8000_0000_0000_0000 : div_q[63:0];
            slope_new = 64'd0 - smag_new;
            sneg_new  = smag_new != 64'd0;
        end
    end

    // item input register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_in_reg <= key[KEY_BITS-1:0];
            v_in_reg <= value[VALUE_BITS-1:0];
        end
    end

    // accumulation, fit captures, batch clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            n_reg     <= '0;
            ksum_reg  <= '0;
            kksum_reg <= '0;
            vsum_reg  <= '0;
            kvsum_reg <= '0;
            vmin_reg  <= '1;
            vmax_reg  <= '0;
            ovf_reg   <= 1'b0;
            slope_reg <= '0;
            smag_reg  <= '0;
            sneg_reg  <= 1'b0;
            icpt_reg  <= '0;
            degen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg <= last;
            end
            if (cmd.acc)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    n_reg     <= n_reg + CW'(1);
                    ksum_reg  <= ksum_reg + SKW'(k_in_reg);
                    kksum_reg <= kksum_reg + SKKW'(k_in_reg * k_in_reg);
                    vsum_reg  <= vsum_reg + SVW'(v_in_reg);
                    kvsum_reg <= kvsum_reg + SKVW'(k_in_reg * v_in_reg);
                    if (v_in_reg < vmin_reg)
                    begin
                        vmin_reg <= v_in_reg;
                    end
                    if (v_in_reg > vmax_reg)
                    begin
                        vmax_reg <= v_in_reg;
                    end
                end
            end
            if (mul_done && cmd.step == ST_KK)
            begin
                degen_reg <= (a_reg - p_lo) == '0;
            end
            if (div_done && cmd.step == ST_SLOPE)
            begin
                slope_reg <= slope_new;
                smag_reg  <= smag_new;
                sneg_reg  <= sneg_new;
            end
            if (div_done && cmd.step == ST_ICPT)
            begin
                icpt_reg <= (div_q[DN_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
            end
            if (cmd.out_go)
            begin
                n_reg     <= '0;
                ksum_reg  <= '0;
                kksum_reg <= '0;
                vsum_reg  <= '0;
                kvsum_reg <= '0;
                vmin_reg  <= '1;
                vmax_reg  <= '0;
                ovf_reg   <= 1'b0;
                slope_reg <= '0;
                smag_reg  <= '0;
                sneg_reg  <= 1'b0;
                icpt_reg  <= '0;
                degen_reg <= 1'b0;
            end
        end
    end

    // intermediate fit terms
    always_ff @(posedge clk)
    begin
        if (div_done && cmd.step == ST_MEAN)
        begin
            mean_reg <= div_q[39:0];
        end
        if (mul_done)
        begin
            case (cmd.step)
                ST_NKK, ST_NKV:
                begin
                    a_reg <= p_lo;
                end
                ST_KK:
                begin
                    den_reg <= a_reg - p_lo;
                end
                ST_KV:
                begin
                    sraw_reg <= a_reg < p_lo;
                    mag_reg  <= (a_reg < p_lo) ? (p_lo - a_reg) : (a_reg - p_lo);
                end
                ST_DENR:
                begin
                    dv_reg <= mul_p;
                end
                ST_NVMIN:
                begin
                    inum_reg <= vsum_reg - mul_p[SVW-1:0];
                end
                ST_NRNG:
                begin
                    iden_reg <= mul_p;
                end
                default:
                begin
                end
            endcase
        end
    end

    // error pass pipeline
    logic          p0_v_reg, a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    logic [AW-1:0] p0_i_reg, a_i_reg, b_i_reg, c_i_reg, d_i_reg, e_i_reg;
    logic          a_neg_reg, b_neg_reg, c_neg_reg;
    logic [39:0]   a_dmag_reg;
    logic [51:0]   pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic [103:0]  t_reg;
    logic [31:0]   f_reg;
    logic [42:0]   pos_reg;

    logic [39:0]  kq;
    logic         dneg;
    logic [39:0]  dmag;
    logic         neg_a;
    logic [103:0] t_sum;
    logic [73:0]  m;
    logic [32:0]  s33;
    logic [31:0]  f_new;
    logic [42:0]  tgt;
    logic [42:0]  err;
    logic [43:0]  e_sum;
    logic [11:0]  e_val;

    always_comb
    begin
        // stage A: key offset from mean
        kq    = {rdata, 16'd0};
        dneg  = kq < mean_reg;
        dmag  = dneg ? (mean_reg - kq) : (kq - mean_reg);
        neg_a = (sneg_reg != dneg) && (smag_reg != '0) && (dmag != '0);
        // stage C: partial product sum
        t_sum = 104'(pp0_reg) + (104'(pp1_reg) << 20) + (104'(pp2_reg) << 32)
              + (104'(pp3_reg) << 52);
        // stage D: shift, round, clamp
        m   = 74'(t_reg[103:31]) + 74'(c_neg_reg && (t_reg[30:0] != '0));
        s33 = {1'b0, m[31:0]} + {1'b0, icpt_reg};
        if (!c_neg_reg)
        begin
            if (m[73:32] != '0 || s33[32])
            begin
                f_new = CLAMP_FRAC;
            end
            else
            begin
                f_new = s33[31:0];
            end
        end
        else
        begin
            f_new = (m[73:32] != '0 || m[31:0] >= icpt_reg) ? 32'd0 : icpt_reg - m[31:0];
        end
        // stage F: error and its ceiling
        tgt   = {1'b0, e_i_reg, 32'd0};
        err   = (tgt >= pos_reg) ? (tgt - pos_reg) : (pos_reg - tgt);
        e_sum = {1'b0, err} + 44'h0_FFFF_FFFF;
        e_val = e_sum[43:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
            d_v_reg  <= 1'b0;
            e_v_reg  <= 1'b0;
            max_reg  <= '0;
        end
        else
        begin
            p0_v_reg <= cmd.rd_go;
            a_v_reg  <= p0_v_reg;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
            d_v_reg  <= c_v_reg;
            e_v_reg  <= d_v_reg;
            if (e_v_reg && e_val > 12'(max_reg))
            begin
                max_reg <= e_val[10:0];
            end
            if (cmd.out_go)
            begin
                max_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p0_i_reg   <= cmd.rd_addr;
        a_i_reg    <= p0_i_reg;
        a_dmag_reg <= dmag;
        a_neg_reg  <= neg_a;
        b_i_reg    <= a_i_reg;
        b_neg_reg  <= a_neg_reg;
        pp0_reg    <= smag_reg[31:0]  * a_dmag_reg[19:0];
        pp1_reg    <= smag_reg[31:0]  * a_dmag_reg[39:20];
        pp2_reg    <= smag_reg[63:32] * a_dmag_reg[19:0];
        pp3_reg    <= smag_reg[63:32] * a_dmag_reg[39:20];
        c_i_reg    <= b_i_reg;
        c_neg_reg  <= b_neg_reg;
        t_reg      <= t_sum;
        d_i_reg    <= c_i_reg;
        f_reg      <= f_new;
        e_i_reg    <= d_i_reg;
        pos_reg    <= f_reg * n_reg;
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.out_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_go)
        begin
            o_slope_reg <= slope_reg;
            o_icpt_reg  <= icpt_reg;
            o_mean_reg  <= mean_reg;
            o_max_reg   <= max_reg;
            o_n_reg     <= n_reg;
            o_degen_reg <= degen_reg;
            o_ovf_reg   <= ovf_reg;
        end
    end

    assign slope_q     = $signed(o_slope_reg);
    assign intercept_q = o_icpt_reg;
    assign key_mean_q  = o_mean_reg;
    assign max_offset  = o_max_reg;
    assign pair_count  = o_n_reg;
    assign degenerate  = o_degen_reg;
    assign overflowed  = o_ovf_reg;
    assign done        = done_reg;

    assign stat.last      = last_reg;
    assign stat.mul_done  = mul_done;
    assign stat.div_done  = div_done;
    assign stat.degen     = degen_reg;
    assign stat.pass_busy = p0_v_reg | a_v_reg | b_v_reg | c_v_reg | d_v_reg | e_v_reg;
    assign stat.n_pairs   = n_reg;

endmodule

### sv/lmfeb_ctrl.sv
// Controller: item intake, fit step sequencing, error pass addressing and result release.
module lmfeb_ctrl import lmfeb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_GO    = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_PASS  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [3:0]    step_reg, step_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          is_div;
    logic          op_done;

    assign is_div  = step_reg == ST_MEAN || step_reg == ST_SLOPE || step_reg == ST_ICPT;
    assign op_done = is_div ? stat.div_done : stat.mul_done;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        cmd.rd_addr = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.last)
                begin
                    step_next  = ST_MEAN;
                    state_next = S_GO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GO:
            begin
                // all equal keys: skip the rest of the fit
                if (step_reg == ST_NKV && stat.degen)
                begin
                    cnt_next   = '0;
                    state_next = S_PASS;
                end
                else
                begin
                    cmd.mul_go = !is_div;
                    cmd.div_go = is_div;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (op_done)
                begin
                    if (step_reg == ST_ICPT)
                    begin
                        cnt_next   = '0;
                        state_next = S_PASS;
                    end
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_GO;
                    end
                end
            end
            S_PASS:
            begin
                cmd.rd_go = 1'b1;
                cnt_next  = cnt_reg + AW'(1);
                if (CW'(cnt_reg) == stat.n_pairs - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pass_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.out_go = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_MEAN;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

### sv/lmfeb_checker.sv
// Port-level checks for the line fit block and their binding to the top level.
module lmfeb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [63:0] slope_q,
    input logic [31:0]        intercept_q,
    input logic [10:0]        max_offset,
    input logic [10:0]        pair_count,
    input logic               degenerate
);

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // equal keys give a flat line
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (slope_q == 64'sd0 && intercept_q == 32'd0))
        else $error("degenerate result with nonzero slope or intercept");

    // error bound never exceeds the pair count
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pair_count != 11'd0 && max_offset <= pair_count))
        else $error("max_offset out of range");

endmodule

bind linear_model_fit_error_bound_top lmfeb_checker u_lmfeb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .slope_q     (slope_q),
    .intercept_q (intercept_q),
    .max_offset  (max_offset),
    .pair_count  (pair_count),
    .degenerate  (degenerate)
);
